@@ rtl/dhp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dhp_pkg;

    // result kinds (carried on the output tuser)
    localparam logic [1:0] KIND_EXT     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_HEADER  = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TYPE  = 2'd1;
    localparam logic [1:0] ERR_SHORT = 2'd2;

    localparam logic [7:0]  PROTO_TYPE    = 8'h04;
    localparam int          OPT_BIT       = 4;
    localparam int          VER_LSB       = 5;
    localparam logic [7:0]  AID_SHORT_MAX = 8'h7F;
    localparam logic [15:0] AID_OFFSET    = 16'h7F80;

    localparam int FIFO_DEPTH = 4;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [11:0] {
        PH_TYPE    = 12'b0000_0000_0001,
        PH_VER     = 12'b0000_0000_0010,
        PH_EXTCNT  = 12'b0000_0000_0100,
        PH_EXTID   = 12'b0000_0000_1000,
        PH_EXTLEN  = 12'b0000_0001_0000,
        PH_EXTDATA = 12'b0000_0010_0000,
        PH_AID1    = 12'b0000_0100_0000,
        PH_AID2    = 12'b0000_1000_0000,
        PH_LENH    = 12'b0001_0000_0000,
        PH_LENL    = 12'b0010_0000_0000,
        PH_PAYLOAD = 12'b0100_0000_0000,
        PH_DROP    = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [7:0]  element_id;
        logic [2:0]  version;
        logic        has_extension;
        logic [15:0] app_id;
        logic [15:0] payload_length;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

    // up to two result words produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

endpackage

`default_nettype wire

@@ rtl/dhp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dhp_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_frame_end,
    output dhp_pkg::t_push     o_push
);

    dhp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_ext_left, n_ext_left;
    logic [7:0]  r_ext_id, n_ext_id;
    logic [7:0]  r_ext_bytes_left, n_ext_bytes_left;
    logic [7:0]  r_id_high, n_id_high;
    logic [7:0]  r_len_high, n_len_high;
    logic [15:0] r_payload_left, n_payload_left;
    logic [2:0]  r_ver, n_ver;
    logic        r_opt, n_opt;
    logic [15:0] r_app, n_app;

    dhp_pkg::t_result prim;
    dhp_pkg::t_result err_res;
    logic        prim_valid;
    logic        done;
    logic        err_valid;
    logic [15:0] len_full;
    logic [15:0] pl_dec;
    logic [7:0]  ebl_dec;

    assign len_full = {r_len_high, i_byte};
    assign pl_dec   = r_payload_left - 16'd1;
    assign ebl_dec  = r_ext_bytes_left - 8'd1;

    always_comb begin
        n_phase          = r_phase;
        n_ext_left       = r_ext_left;
        n_ext_id         = r_ext_id;
        n_ext_bytes_left = r_ext_bytes_left;
        n_id_high        = r_id_high;
        n_len_high       = r_len_high;
        n_payload_left   = r_payload_left;
        n_ver            = r_ver;
        n_opt            = r_opt;
        n_app            = r_app;
        prim             = '0;
        prim_valid       = 1'b0;
        done             = 1'b0;

        unique case (r_phase)
            dhp_pkg::PH_TYPE: begin
                if (i_byte != dhp_pkg::PROTO_TYPE) begin
                    prim.kind       = dhp_pkg::KIND_ERROR;
                    prim.error_code = dhp_pkg::ERR_TYPE;
                    prim_valid      = 1'b1;
                    n_phase         = dhp_pkg::PH_DROP;
                    done            = 1'b1;
                end else begin
                    n_phase = dhp_pkg::PH_VER;
                end
            end
            dhp_pkg::PH_VER: begin
                n_ver   = i_byte[dhp_pkg::VER_LSB +: 3];
                n_opt   = i_byte[dhp_pkg::OPT_BIT];
                n_phase = i_byte[dhp_pkg::OPT_BIT] ? dhp_pkg::PH_EXTCNT : dhp_pkg::PH_AID1;
            end
            dhp_pkg::PH_EXTCNT: begin
                n_ext_left = i_byte;
                n_phase    = (i_byte != 8'd0) ? dhp_pkg::PH_EXTID : dhp_pkg::PH_AID1;
            end
            dhp_pkg::PH_EXTID: begin
                n_ext_id = i_byte;
                n_phase  = dhp_pkg::PH_EXTLEN;
            end
            dhp_pkg::PH_EXTLEN: begin
                n_ext_bytes_left = i_byte;
                if (i_byte == 8'd0) begin
                    // empty extension: step to the next one
                    n_ext_left = r_ext_left - 8'd1;
                    n_phase    = (r_ext_left != 8'd1) ? dhp_pkg::PH_EXTID : dhp_pkg::PH_AID1;
                end else begin
                    n_phase = dhp_pkg::PH_EXTDATA;
                end
            end
            dhp_pkg::PH_EXTDATA: begin
                prim.kind        = dhp_pkg::KIND_EXT;
                prim.data        = i_byte;
                prim.element_id  = r_ext_id;
                prim_valid       = 1'b1;
                n_ext_bytes_left = ebl_dec;
                if (ebl_dec == 8'd0) begin
                    n_ext_left = r_ext_left - 8'd1;
                    n_phase    = (r_ext_left != 8'd1) ? dhp_pkg::PH_EXTID : dhp_pkg::PH_AID1;
                end
            end
            dhp_pkg::PH_AID1: begin
                if (i_byte <= dhp_pkg::AID_SHORT_MAX) begin
                    n_app   = {8'd0, i_byte};
                    n_phase = dhp_pkg::PH_LENH;
                end else begin
                    n_id_high = i_byte;
                    n_phase   = dhp_pkg::PH_AID2;
                end
            end
            dhp_pkg::PH_AID2: begin
                n_app   = {r_id_high, i_byte} - dhp_pkg::AID_OFFSET;
                n_phase = dhp_pkg::PH_LENH;
            end
            dhp_pkg::PH_LENH: begin
                n_len_high = i_byte;
                n_phase    = dhp_pkg::PH_LENL;
            end
            dhp_pkg::PH_LENL: begin
                prim.kind           = dhp_pkg::KIND_HEADER;
                prim.version        = r_ver;
                prim.has_extension  = r_opt;
                prim.app_id         = r_app;
                prim.payload_length = len_full;
                prim_valid          = 1'b1;
                n_payload_left      = len_full;
                if (len_full == 16'd0) begin
                    n_phase = dhp_pkg::PH_DROP;
                    done    = 1'b1;
                end else begin
                    n_phase = dhp_pkg::PH_PAYLOAD;
                end
            end
            dhp_pkg::PH_PAYLOAD: begin
                prim.kind      = dhp_pkg::KIND_PAYLOAD;
                prim.data      = i_byte;
                prim.last      = (pl_dec == 16'd0);
                prim_valid     = 1'b1;
                n_payload_left = pl_dec;
                if (pl_dec == 16'd0) begin
                    n_phase = dhp_pkg::PH_DROP;
                    done    = 1'b1;
                end
            end
            default: begin
                n_phase = dhp_pkg::PH_DROP;
                done    = 1'b1;
            end
        endcase

        if (i_frame_end) begin
            n_phase = dhp_pkg::PH_TYPE;
        end
    end

    assign err_valid = i_frame_end && !done;

    always_comb begin
        err_res            = '0;
        err_res.kind       = dhp_pkg::KIND_ERROR;
        err_res.error_code = dhp_pkg::ERR_SHORT;
        o_push             = '0;
        if (i_accept) begin
            if (prim_valid) begin
                o_push.slot0 = prim;
                o_push.slot1 = err_res;
                o_push.count = err_valid ? 2'd2 : 2'd1;
            end else begin
                o_push.slot0 = err_res;
                o_push.count = err_valid ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= dhp_pkg::PH_TYPE;
            r_ext_left       <= '0;
            r_ext_id         <= '0;
            r_ext_bytes_left <= '0;
            r_id_high        <= '0;
            r_len_high       <= '0;
            r_payload_left   <= '0;
            r_ver            <= '0;
            r_opt            <= 1'b0;
            r_app            <= '0;
        end else if (i_accept) begin
            r_phase          <= n_phase;
            r_ext_left       <= n_ext_left;
            r_ext_id         <= n_ext_id;
            r_ext_bytes_left <= n_ext_bytes_left;
            r_id_high        <= n_id_high;
            r_len_high       <= n_len_high;
            r_payload_left   <= n_payload_left;
            r_ver            <= n_ver;
            r_opt            <= n_opt;
            r_app            <= n_app;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dhp_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dhp_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dhp_pkg::t_push   i_push,
    input  wire logic             i_pop,
    output dhp_pkg::t_result      o_head,
    output logic                  o_not_empty,
    output logic                  o_room_for_two
);

    localparam int PTR_W = $clog2(dhp_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(dhp_pkg::FIFO_DEPTH + 1);

    dhp_pkg::t_result r_mem [dhp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr_next;
    logic             pop_ok;

    assign wr_next        = r_wr + PTR_W'(1);
    assign pop_ok         = i_pop && (r_count != '0);
    assign o_not_empty    = (r_count != '0);
    assign o_room_for_two = (r_count <= CNT_W'(dhp_pkg::FIFO_DEPTH - 2));
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.count);
            r_rd    <= r_rd + PTR_W'(pop_ok);
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(pop_ok);
        end
    end

endmodule

`default_nettype wire

@@ rtl/dhp_header_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Header parser for short-message network frames, one byte per word.
// Slave stream: tdata carries the frame byte, tlast marks the last byte of
// the buffer. Master stream: one word per result; tuser gives the kind
// (extension byte, payload byte, header complete, frame error), tlast flags
// the final payload byte, tdata carries the data byte, element id, decoded
// header fields and error code. A result enters a four-word output buffer
// as the byte that causes it is taken, and is offered on the master side
// once the words ahead of it have gone out. Throughput: one byte per cycle
// while the buffer has room for two words; the parse state updates in the
// same cycle the byte is taken. A byte that yields a result and also ends
// the frame early occupies two buffer words. The slave side drops tready
// when fewer than two buffer words are free, so a stalled receiver backs up
// into the sender once the buffer holds more than two words; nothing is lost.
// Reset (synchronous, active low) empties the buffer and returns the parser
// to waiting for a protocol type byte.
module dsmp_header_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,   // frame_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [7:0] out_byte, [15:8] element_id, [18:16] version, [19] has_extension,
    // [35:20] app_id, [51:36] payload_length, [53:52] error_code, [55:54] zero
    output logic [dhp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]       o_m_tuser,   // [1:0] out_kind
    output logic             o_m_tlast    // last
);

    dhp_pkg::t_push   push;
    dhp_pkg::t_result head;
    logic             accept;
    logic             room_for_two;

    assign o_s_tready = room_for_two;
    assign accept     = i_s_tvalid && room_for_two;

    dhp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_frame_end (i_s_tlast),
        .o_push      (push)
    );

    dhp_out_fifo u_out_fifo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_pop          (i_m_tready),
        .o_head         (head),
        .o_not_empty    (o_m_tvalid),
        .o_room_for_two (room_for_two)
    );

    assign o_m_tdata = {2'b00, head.error_code, head.payload_length, head.app_id,
                        head.has_extension, head.version, head.element_id, head.data};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

`default_nettype wire

@@ tb/dsmp_header_parser_unit_tb.sv @@
`timescale 1ns / 1ps

module dsmp_header_parser_unit_tb;

    localparam int RX_OPEN   = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_BLOCKY = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] in_byte
    logic        i_s_tlast = 1'b0;    // frame_end
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [7:0] out_byte, [15:8] element_id, [18:16] version, [19] has_extension,
    // [35:20] app_id, [51:36] payload_length, [53:52] error_code, [55:54] zero
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;           // [1:0] out_kind
    logic        o_m_tlast;

    dsmp_header_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_frame_byte      frame_bytes[$];
    dhp_pkg::t_result results_due[$];

    int n_planned;
    int n_taken;
    int n_frames;
    int n_bad;
    int kind_count[4];

    // parser shadow state
    dhp_pkg::t_phase ph;
    logic [7:0]  ext_left;
    logic [7:0]  ext_id;
    logic [7:0]  ext_bytes;
    logic [7:0]  id_hi;
    logic [15:0] len_q;
    logic [15:0] pay_left;
    logic [15:0] app_q;
    logic [2:0]  ver_q;
    logic        opt_q;

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return b;
    endfunction

    task automatic close_extension();
        ext_left = ext_left - 8'd1;
        ph = (ext_left != 8'd0) ? dhp_pkg::PH_EXTID : dhp_pkg::PH_AID1;
    endtask

    // Work out the result words that one accepted frame byte produces.
    task automatic parse_byte(input logic [7:0] b, input logic fe);
        dhp_pkg::t_result r;
        logic    ended;
        ended = 1'b0;
        r = '0;
        case (ph)
            dhp_pkg::PH_TYPE: begin
                if (b != dhp_pkg::PROTO_TYPE) begin
                    r.kind = dhp_pkg::KIND_ERROR;
                    r.error_code = dhp_pkg::ERR_TYPE;
                    results_due.push_back(r);
                    ph = dhp_pkg::PH_DROP;
                    ended = 1'b1;
                end else begin
                    ph = dhp_pkg::PH_VER;
                end
            end
            dhp_pkg::PH_VER: begin
                ver_q = b[7:5];
                opt_q = b[dhp_pkg::OPT_BIT];
                ph = opt_q ? dhp_pkg::PH_EXTCNT : dhp_pkg::PH_AID1;
            end
            dhp_pkg::PH_EXTCNT: begin
                ext_left = b;
                ph = (b != 8'd0) ? dhp_pkg::PH_EXTID : dhp_pkg::PH_AID1;
            end
            dhp_pkg::PH_EXTID: begin
                ext_id = b;
                ph = dhp_pkg::PH_EXTLEN;
            end
            dhp_pkg::PH_EXTLEN: begin
                ext_bytes = b;
                if (b == 8'd0) close_extension();
                else ph = dhp_pkg::PH_EXTDATA;
            end
            dhp_pkg::PH_EXTDATA: begin
                r.kind = dhp_pkg::KIND_EXT;
                r.data = b;
                r.element_id = ext_id;
                results_due.push_back(r);
                ext_bytes = ext_bytes - 8'd1;
                if (ext_bytes == 8'd0) close_extension();
            end
            dhp_pkg::PH_AID1: begin
                if (b <= dhp_pkg::AID_SHORT_MAX) begin
                    app_q = {8'h00, b};
                    ph = dhp_pkg::PH_LENH;
                end else begin
                    id_hi = b;
                    ph = dhp_pkg::PH_AID2;
                end
            end
            dhp_pkg::PH_AID2: begin
                app_q = {id_hi, b} - dhp_pkg::AID_OFFSET;
                ph = dhp_pkg::PH_LENH;
            end
            dhp_pkg::PH_LENH: begin
                len_q = {b, 8'h00};
                ph = dhp_pkg::PH_LENL;
            end
            dhp_pkg::PH_LENL: begin
                len_q[7:0] = b;
                r.kind = dhp_pkg::KIND_HEADER;
                r.version = ver_q;
                r.has_extension = opt_q;
                r.app_id = app_q;
                r.payload_length = len_q;
                results_due.push_back(r);
                pay_left = len_q;
                if (len_q == 16'd0) begin
                    ph = dhp_pkg::PH_DROP;
                    ended = 1'b1;
                end else begin
                    ph = dhp_pkg::PH_PAYLOAD;
                end
            end
            dhp_pkg::PH_PAYLOAD: begin
                pay_left = pay_left - 16'd1;
                r.kind = dhp_pkg::KIND_PAYLOAD;
                r.data = b;
                r.last = (pay_left == 16'd0);
                results_due.push_back(r);
                if (pay_left == 16'd0) begin
                    ph = dhp_pkg::PH_DROP;
                    ended = 1'b1;
                end
            end
            default: begin
                ph = dhp_pkg::PH_DROP;
                ended = 1'b1;
            end
        endcase
        if (fe) begin
            if (!ended) begin
                r = '0;
                r.kind = dhp_pkg::KIND_ERROR;
                r.error_code = dhp_pkg::ERR_SHORT;
                results_due.push_back(r);
            end
            ph = dhp_pkg::PH_TYPE;
        end
    endtask

    // Queue n bytes given first-byte-in-MSB; frame_end goes on the final one.
    task automatic add_raw(input int n, input logic [127:0] v);
        t_frame_byte fb;
        for (int i = n - 1; i >= 0; i--) begin
            fb.data = v[8*i +: 8];
            fb.frame_end = (i == 0);
            frame_bytes.push_back(fb);
        end
        n_frames++;
    endtask

    // n_ext < 0 clears the extension flag; cut ends the frame at a random byte.
    task automatic add_frame(input int n_ext, input int app, input int plen,
                             input bit cut, input int trail, input bit bad_type);
        logic [7:0]  fb[$];
        logic [7:0]  b;
        logic [15:0] code;
        logic [15:0] len16;
        int          ln;
        int          keep;
        t_frame_byte item;
        b = rand_byte();
        if (bad_type && b == dhp_pkg::PROTO_TYPE) b = ~b;
        fb.push_back(bad_type ? b : dhp_pkg::PROTO_TYPE);
        b = rand_byte();
        b[dhp_pkg::OPT_BIT] = (n_ext >= 0);
        fb.push_back(b);
        if (n_ext >= 0) begin
            fb.push_back(n_ext[7:0]);
            repeat (n_ext) begin
                ln = $urandom_range(0, 4);
                fb.push_back(rand_byte());
                fb.push_back(ln[7:0]);
                repeat (ln) fb.push_back(rand_byte());
            end
        end
        if (app <= dhp_pkg::AID_SHORT_MAX) begin
            fb.push_back(app[7:0]);
        end else begin
            code = app[15:0] + dhp_pkg::AID_OFFSET;
            fb.push_back(code[15:8]);
            fb.push_back(code[7:0]);
        end
        len16 = plen[15:0];
        fb.push_back(len16[15:8]);
        fb.push_back(len16[7:0]);
        repeat (plen) fb.push_back(rand_byte());
        if (cut) begin
            keep = $urandom_range(1, fb.size() - 1);
            while (fb.size() > keep) void'(fb.pop_back());
        end else begin
            repeat (trail) fb.push_back(rand_byte());
        end
        foreach (fb[i]) begin
            item.data = fb[i];
            item.frame_end = (i == fb.size() - 1);
            frame_bytes.push_back(item);
        end
        n_frames++;
    endtask

    // Sender: bursts of words separated by random gaps.
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_frame_byte next_item;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= 8'h00;
            i_s_tlast <= 1'b0;
            ph = dhp_pkg::PH_TYPE;
            ext_left = '0;
            ext_id = '0;
            ext_bytes = '0;
            id_hi = '0;
            len_q = '0;
            pay_left = '0;
            app_q = '0;
            ver_q = '0;
            opt_q = 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                parse_byte(i_s_tdata, i_s_tlast);
                n_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left != 0 || frame_bytes.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    i_s_tvalid <= 1'b0;
                end else begin
                    next_item = frame_bytes.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= next_item.data;
                    i_s_tlast <= next_item.frame_end;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // Receiver: switch between open, choppy and long-stall behavior.
    int rx_cycle = 0;
    int rx_mode = RX_OPEN;
    int rx_stall = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 128 == 0) rx_mode = $urandom_range(RX_OPEN, RX_BLOCKY);
            if (rx_stall != 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN: i_m_tready <= 1'b1;
                    RX_CHOPPY: i_m_tready <= 1'($urandom_range(0, 1));
                    default: begin
                        if ($urandom_range(0, 9) == 0) begin
                            rx_stall = $urandom_range(4, 24);
                            i_m_tready <= 1'b0;
                        end else begin
                            i_m_tready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    task automatic note_mismatch(input string why, input dhp_pkg::t_result want,
                                 input dhp_pkg::t_result got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("%0t %s: want k=%0d b=%h eid=%h v=%0d x=%0b app=%h len=%h err=%0d l=%0b",
                     $realtime, why, want.kind, want.data, want.element_id, want.version,
                     want.has_extension, want.app_id, want.payload_length, want.error_code,
                     want.last);
            $display("%0t %s: got  k=%0d b=%h eid=%h v=%0d x=%0b app=%h len=%h err=%0d l=%0b",
                     $realtime, why, got.kind, got.data, got.element_id, got.version,
                     got.has_extension, got.app_id, got.payload_length, got.error_code,
                     got.last);
        end
    endtask

    always @(posedge i_clk) begin
        dhp_pkg::t_result got;
        dhp_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '0;
            got.kind = o_m_tuser;
            got.data = o_m_tdata[7:0];
            got.element_id = o_m_tdata[15:8];
            got.version = o_m_tdata[18:16];
            got.has_extension = o_m_tdata[19];
            got.app_id = o_m_tdata[35:20];
            got.payload_length = o_m_tdata[51:36];
            got.error_code = o_m_tdata[53:52];
            got.last = o_m_tlast;
            kind_count[got.kind]++;
            if (results_due.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                want = results_due.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.element_id !== want.element_id || got.version !== want.version ||
                    got.has_extension !== want.has_extension || got.app_id !== want.app_id ||
                    got.payload_length !== want.payload_length ||
                    got.error_code !== want.error_code || got.last !== want.last)
                    note_mismatch("mismatch", want, got);
            end
        end
    end

    initial begin
        int   sel;
        int   n_ext;
        int   app;
        int   plen;
        int   trail;
        t_frame_byte nb;
        i_rst_n = 1'b0;

        add_raw(1, 128'h00);                              // bad type, ends at once
        add_raw(2, 128'hFF12);                            // bad type, rest dropped
        add_raw(1, 128'h04);                              // ends right after type
        add_raw(7, 128'h04E0FFFFFFFF5A);                  // max app id and length, cut short
        add_raw(15, 128'h041F02FF01AA000080000002112233); // two extensions, trailing byte
        add_raw(6, 128'h041001050377);                    // ends on an extension data byte
        add_raw(6, 128'h0450007F0000);                    // zero extensions, zero payload
        n_planned = frame_bytes.size();

        while (frame_bytes.size() < n_planned + 450) begin
            sel = $urandom_range(0, 19);
            n_ext = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 3);
            app = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(128, 32895);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            if (sel < 12) begin
                add_frame(n_ext, app, plen, 1'b0, trail, 1'b0);
            end else if (sel < 15) begin
                add_frame(n_ext, app, plen, 1'b1, 0, 1'b0);
            end else if (sel < 17) begin
                add_frame(n_ext, app, plen, 1'b0, trail, 1'b1);
            end else begin
                // noise, often starting on a valid type byte; close it with frame_end
                repeat ($urandom_range(1, 10)) begin
                    nb.data = $urandom_range(0, 1) ? dhp_pkg::PROTO_TYPE : rand_byte();
                    nb.frame_end = ($urandom_range(0, 5) == 0);
                    frame_bytes.push_back(nb);
                end
                nb.data = rand_byte();
                nb.frame_end = 1'b1;
                frame_bytes.push_back(nb);
                n_frames++;
            end
        end
        n_planned = frame_bytes.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_planned) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d frames in %0d bytes, directed corner frames plus random traffic",
                 n_frames, n_taken);
        $display("checked %0d extension, %0d payload, %0d header and %0d error words",
                 kind_count[dhp_pkg::KIND_EXT], kind_count[dhp_pkg::KIND_PAYLOAD],
                 kind_count[dhp_pkg::KIND_HEADER], kind_count[dhp_pkg::KIND_ERROR]);
        if (n_bad == 0) begin
            $display("dsmp_header_parser_unit_tb passed");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("dsmp_header_parser_unit_tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d words still due", results_due.size());
        $display("dsmp_header_parser_unit_tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dhp_pkg.sv
rtl/dhp_parser.sv
rtl/dhp_out_fifo.sv
rtl/dhp_header_parser_unit.sv
tb/dsmp_header_parser_unit_tb.sv
